>>> rtl/core/wwfr_pkg.sv
// shared types and constants for the whole-word find and replace block
package wwfr_pkg;

   localparam int WORD_BYTES = 16;
   localparam int WORD_IDX_W = 4;
   localparam int LEN_W      = 5;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_FIND_LO  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIND_HI  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIND_LEN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPL_LO  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPL_HI  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REPL_LEN = 3'd5;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       out_last;
      logic       word_found;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic step_match;
      logic step_pass;
      logic emit_repl;
      logic flush;
   } dp_cmd_type;

   typedef struct packed {
      logic more;
      logic match;
      logic repl_none;
      logic repl_done;
      logic emit_ok;
      logic out_free;
      logic hold_valid;
      logic last;
   } dp_status_type;

endpackage

>>> rtl/core/wwfr_dp.sv
// datapath: config registers, lookahead window, matcher and result registers
module wwfr_dp #(
   parameter int MAX_WORD = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [wwfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wwfr_pkg::CSR_DATA_W-1:0]  csr_data,
   input  wwfr_pkg::req_type                req_data,
   input  wwfr_pkg::dp_cmd_type             cmd,
   output wwfr_pkg::dp_status_type          status,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output wwfr_pkg::rsp_type                rsp_data
);

   localparam int DEPTH  = MAX_WORD + 1;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   function automatic logic [7:0] fold(input logic [7:0] c);
      fold = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
   endfunction

   function automatic logic is_boundary(input logic [7:0] c);
      is_boundary = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13) ||
                    (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
                    (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
   endfunction

   logic [wwfr_pkg::CSR_DATA_W-1:0] find_lo_ff, find_lo_in, find_hi_ff, find_hi_in;
   logic [wwfr_pkg::CSR_DATA_W-1:0] repl_lo_ff, repl_lo_in, repl_hi_ff, repl_hi_in;
   logic [wwfr_pkg::LEN_W-1:0]      find_len_ff, find_len_in, repl_len_ff, repl_len_in;

   logic [7:0]        win_ff [DEPTH];
   logic [7:0]        win_in [DEPTH];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        prev_ff, prev_in;
   logic              at_start_ff, at_start_in;
   logic              any_ff, any_in;
   logic              last_ff, last_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;

   logic              hold_valid_ff, hold_valid_in;
   logic [7:0]        hold_byte_ff, hold_byte_in;
   logic              rsp_valid_ff, rsp_valid_in;
   wwfr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [8*wwfr_pkg::WORD_BYTES-1:0] find_word, repl_word;
   logic [IDX_W-1:0]                  flen, rlen, drop_amt;
   logic [FILL_W-1:0]                 flen_fill;
   logic                              chars_ok, left_ok, right_ok, match;
   logic                              clear_stream, out_free, emit;
   logic [7:0]                        emit_byte, repl_byte;
   logic [wwfr_pkg::WORD_IDX_W-1:0]   repl_idx;
   logic [8*DEPTH-1:0]                win_flat, win_shift;

   assign find_word = {find_hi_ff, find_lo_ff};
   assign repl_word = {repl_hi_ff, repl_lo_ff};
   assign flen = (find_len_ff > wwfr_pkg::LEN_W'(MAX_WORD)) ? IDX_W'(MAX_WORD)
                                                            : IDX_W'(find_len_ff);
   assign rlen = (repl_len_ff > wwfr_pkg::LEN_W'(MAX_WORD)) ? IDX_W'(MAX_WORD)
                                                            : IDX_W'(repl_len_ff);
   assign flen_fill = FILL_W'(flen);

   // case-folded compare of the window head against the search word
   always_comb begin
      chars_ok = 1'b1;
      for (int j = 0; j < MAX_WORD; j++) begin
         if (IDX_W'(j) < flen && fold(win_ff[j]) != fold(find_word[8*j +: 8])) begin
            chars_ok = 1'b0;
         end
      end
   end

   assign left_ok  = at_start_ff || is_boundary(prev_ff);
   assign right_ok = (fill_ff == flen_fill) || is_boundary(win_ff[flen]);
   assign match    = (flen != '0) && (fill_ff >= flen_fill) && left_ok && right_ok
                     && chars_ok;

   assign repl_idx  = wwfr_pkg::WORD_IDX_W'(cnt_ff);
   assign repl_byte = repl_word[{repl_idx, 3'b000} +: 8];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = cmd.step_pass || cmd.emit_repl;
   assign emit_byte = cmd.step_pass ? win_ff[0] : repl_byte;

   always_comb begin
      status.more       = (fill_ff != '0) && ((fill_ff > flen_fill) || last_ff);
      status.match      = match;
      status.repl_none  = (rlen == '0);
      status.repl_done  = (IDX_W'(cnt_ff + 1'b1) == rlen);
      status.emit_ok    = !hold_valid_ff || out_free;
      status.out_free   = out_free;
      status.hold_valid = hold_valid_ff;
      status.last       = last_ff;
   end

   // config writes
   always_comb begin
      find_lo_in   = find_lo_ff;
      find_hi_in   = find_hi_ff;
      find_len_in  = find_len_ff;
      repl_lo_in   = repl_lo_ff;
      repl_hi_in   = repl_hi_ff;
      repl_len_in  = repl_len_ff;
      clear_stream = cmd.flush && last_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            wwfr_pkg::CSR_FIND_LO: begin
               find_lo_in = csr_data;
            end
            wwfr_pkg::CSR_FIND_HI: begin
               find_hi_in = csr_data;
            end
            wwfr_pkg::CSR_FIND_LEN: begin
               find_len_in  = csr_data[wwfr_pkg::LEN_W-1:0];
               clear_stream = 1'b1;
            end
            wwfr_pkg::CSR_REPL_LO: begin
               repl_lo_in = csr_data;
            end
            wwfr_pkg::CSR_REPL_HI: begin
               repl_hi_in = csr_data;
            end
            wwfr_pkg::CSR_REPL_LEN: begin
               repl_len_in = csr_data[wwfr_pkg::LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // window and stream state
   always_comb begin
      drop_amt = cmd.step_match ? flen : IDX_W'(1);
      for (int i = 0; i < DEPTH; i++) begin
         win_flat[8*i +: 8] = win_ff[i];
      end
      win_shift = win_flat >> {drop_amt, 3'b000};

      win_in      = win_ff;
      fill_in     = fill_ff;
      prev_in     = prev_ff;
      at_start_in = at_start_ff;
      any_in      = any_ff;
      last_in     = last_ff;
      cnt_in      = cnt_ff;

      if (clear_stream) begin
         for (int i = 0; i < DEPTH; i++) begin
            win_in[i] = 8'd0;
         end
         fill_in     = '0;
         prev_in     = 8'd0;
         at_start_in = 1'b1;
         any_in      = 1'b0;
      end else if (cmd.push) begin
         win_in[fill_ff[IDX_W-1:0]] = req_data.in_byte;
         fill_in = fill_ff + 1'b1;
         last_in = req_data.in_last;
      end else if (cmd.step_match || cmd.step_pass) begin
         for (int i = 0; i < DEPTH; i++) begin
            win_in[i] = win_shift[8*i +: 8];
         end
         at_start_in = 1'b0;
         if (cmd.step_match) begin
            fill_in = fill_ff - flen_fill;
            prev_in = win_ff[IDX_W'(flen - 1'b1)];
            any_in  = 1'b1;
            cnt_in  = '0;
         end else begin
            fill_in = fill_ff - 1'b1;
            prev_in = win_ff[0];
         end
      end else if (cmd.emit_repl) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // one result held back so the final one can be marked
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      if (emit) begin
         if (hold_valid_ff) begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.out_byte     = hold_byte_ff;
            rsp_data_in.byte_present = 1'b1;
            rsp_data_in.out_last     = 1'b0;
            rsp_data_in.word_found   = 1'b0;
         end
         hold_valid_in = 1'b1;
         hold_byte_in  = emit_byte;
      end else if (cmd.flush) begin
         if (hold_valid_ff) begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.out_byte     = hold_byte_ff;
            rsp_data_in.byte_present = 1'b1;
            rsp_data_in.out_last     = last_ff;
            rsp_data_in.word_found   = last_ff && any_ff;
         end else if (last_ff) begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.out_byte     = 8'd0;
            rsp_data_in.byte_present = 1'b0;
            rsp_data_in.out_last     = 1'b1;
            rsp_data_in.word_found   = any_ff;
         end
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         find_lo_ff    <= '0;
         find_hi_ff    <= '0;
         find_len_ff   <= wwfr_pkg::LEN_W'(1);
         repl_lo_ff    <= '0;
         repl_hi_ff    <= '0;
         repl_len_ff   <= '0;
         for (int i = 0; i < DEPTH; i++) begin
            win_ff[i] <= 8'd0;
         end
         fill_ff       <= '0;
         prev_ff       <= 8'd0;
         at_start_ff   <= 1'b1;
         any_ff        <= 1'b0;
         last_ff       <= 1'b0;
         cnt_ff        <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         find_lo_ff    <= find_lo_in;
         find_hi_ff    <= find_hi_in;
         find_len_ff   <= find_len_in;
         repl_lo_ff    <= repl_lo_in;
         repl_hi_ff    <= repl_hi_in;
         repl_len_ff   <= repl_len_in;
         win_ff        <= win_in;
         fill_ff       <= fill_in;
         prev_ff       <= prev_in;
         at_start_ff   <= at_start_in;
         any_ff        <= any_in;
         last_ff       <= last_in;
         cnt_ff        <= cnt_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      hold_byte_ff <= hold_byte_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> fill_ff <= flen_fill)
      else $error("window overfilled on request");
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.step_pass || cmd.emit_repl) |-> status.emit_ok)
      else $error("byte emitted with no room");
   a_final_out: assert property (@(posedge clock) disable iff (reset)
      (cmd.flush && last_ff) |=> rsp_valid_ff && rsp_data_ff.out_last && fill_ff == '0)
      else $error("end of text not delivered");
`endif

endmodule

>>> rtl/core/wwfr_ctrl.sv
// controller: sequences accept, scan, replacement output and flush per request
module wwfr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  wwfr_pkg::dp_status_type status,
   output wwfr_pkg::dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_REPL  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.push = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!status.more) begin
               state_in = ST_FLUSH;
            end else if (status.match) begin
               cmd.step_match = 1'b1;
               if (!status.repl_none) begin
                  state_in = ST_REPL;
               end
            end else if (status.emit_ok) begin
               cmd.step_pass = 1'b1;
            end
         end
         ST_REPL: begin
            if (status.emit_ok) begin
               cmd.emit_repl = 1'b1;
               if (status.repl_done) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_FLUSH: begin
            if (status.out_free || !(status.hold_valid || status.last)) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_cmd_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command");
   a_repl_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPL) |-> !status.repl_none)
      else $error("replacement output with empty replacement");
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_SCAN)
      else $error("request accepted without scan");
`endif

endmodule

>>> rtl/core/whole_word_find_replace.sv
// top level of the case-insensitive whole-word find and replace block
//
//   channel   ports                                  direction  payload
//   request   req_valid, req_stall, req_data         in         wwfr_pkg::req_type
//   response  rsp_valid, rsp_stall, rsp_data         out        wwfr_pkg::rsp_type
//   config    csr_write_en, csr_index, csr_data      in         64-bit register write
//
// a request is accepted, then the scan passes bytes, takes matched words and emits the
// replacement bytes, waiting for room at the output, until the scan is done, then flushes
// the scan controller handles one request at a time through the lookahead window
// response stall holds the output register; one more result waits in the hold stage
// reset is synchronous and restores config and stream state at once, no clearing pass
module whole_word_find_replace #(
   parameter int MAX_WORD = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  wwfr_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output wwfr_pkg::rsp_type               rsp_data,
   input  logic                            csr_write_en,
   input  logic [wwfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wwfr_pkg::CSR_DATA_W-1:0] csr_data
);

   wwfr_pkg::dp_cmd_type    cmd;
   wwfr_pkg::dp_status_type status;

   wwfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wwfr_dp #(
      .MAX_WORD (MAX_WORD)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_data     (req_data),
      .cmd          (cmd),
      .status       (status),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

endmodule

>>> tb/sv/whole_word_find_replace_tb.sv
// self-checking testbench for the whole-word find and replace block
module whole_word_find_replace_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WORD      = 16;
   localparam int DRAIN_CYCLES  = 48;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 320;
   localparam int END_WAIT      = 20000;
   localparam int CYCLE_LIMIT   = 1000000;

   localparam logic [wwfr_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [wwfr_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   wwfr_pkg::req_type               req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   wwfr_pkg::rsp_type               rsp_data;
   logic                            csr_write_en = 1'b0;
   logic [wwfr_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [wwfr_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // predictor copy of the registers and the stream state
   logic [63:0] cfg_find_lo, cfg_find_hi, cfg_repl_lo, cfg_repl_hi;
   logic [4:0]  cfg_find_len, cfg_repl_len;
   logic [7:0]  win_bytes [0:MAX_WORD];
   int          win_fill;
   logic [7:0]  prev_byte;
   bit          at_start;
   bit          any_hit;

   wwfr_pkg::rsp_type pending_text_out [$];

   int unsigned req_sent = 0;
   int unsigned rsp_checked = 0;
   int unsigned hits_predicted = 0;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   int unsigned random_sent = 0;

   bit          gaps_on = 1'b1;
   bit          stalls_on = 1'b1;
   int unsigned hold_asked = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   int unsigned wait_left = 0;
   int unsigned rsp_drawn = 0;

   wwfr_pkg::rsp_type got, want;

   whole_word_find_replace #(.MAX_WORD(MAX_WORD)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit is_sep(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13) || (c >= 8'd33 && c <= 8'd47) ||
             (c >= 8'd58 && c <= 8'd64) || (c >= 8'd91 && c <= 8'd96) ||
             (c >= 8'd123 && c <= 8'd126);
   endfunction

   function automatic logic [7:0] fold(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

   function automatic logic [7:0] word_at(logic [63:0] lo, logic [63:0] hi, int k);
      if (k < 8)
         return lo[k*8 +: 8];
      return hi[(k-8)*8 +: 8];
   endfunction

   function automatic wwfr_pkg::rsp_type text_out(logic [7:0] b, logic present);
      wwfr_pkg::rsp_type o;
      o.out_byte     = b;
      o.byte_present = present;
      o.out_last     = 1'b0;
      o.word_found   = 1'b0;
      return o;
   endfunction

   function automatic logic [7:0] mix_case(logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      if (l >= 8'h61 && l <= 8'h7A)
         return ($urandom_range(0, 1) != 0) ? l : (c & 8'hDF);
      return c;
   endfunction

   function automatic logic [7:0] rand_letter();
      return mix_case(8'(8'h61 + $urandom_range(0, 25)));
   endfunction

   function automatic logic [7:0] rand_sep();
      unique case ($urandom_range(0, 5))
         0: return 8'($urandom_range(9, 13));
         1: return 8'd32;
         2: return 8'($urandom_range(33, 47));
         3: return 8'($urandom_range(58, 64));
         4: return 8'($urandom_range(91, 96));
         default: return 8'($urandom_range(123, 126));
      endcase
   endfunction

   function automatic logic [63:0] rand_word_half();
      logic [63:0] v;
      for (int k = 0; k < 8; k++)
         v[k*8 +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : rand_letter();
      return v;
   endfunction

   function automatic void clear_stream();
      for (int i = 0; i <= MAX_WORD; i++)
         win_bytes[i] = 8'h00;
      win_fill  = 0;
      prev_byte = 8'h00;
      at_start  = 1'b1;
      any_hit   = 1'b0;
   endfunction

   function automatic void drop_front(int count);
      if (count > win_fill)
         count = win_fill;
      for (int i = 0; i <= MAX_WORD; i++) begin
         if (i + count < win_fill)
            win_bytes[i] = win_bytes[i + count];
         else
            win_bytes[i] = 8'h00;
      end
      win_fill -= count;
   endfunction

   task automatic scan_byte(wwfr_pkg::req_type r);
      wwfr_pkg::rsp_type outs [$];
      wwfr_pkg::rsp_type o;
      int      flen, rlen, j;
      bit      hit;
      flen = (cfg_find_len > MAX_WORD) ? MAX_WORD : cfg_find_len;
      rlen = (cfg_repl_len > MAX_WORD) ? MAX_WORD : cfg_repl_len;
      if (win_fill > MAX_WORD)
         drop_front(win_fill - MAX_WORD);
      win_bytes[win_fill] = r.in_byte;
      win_fill++;
      while (win_fill > 0 && (win_fill > flen || r.in_last)) begin
         hit = 1'b0;
         if (flen > 0 && win_fill >= flen && (at_start || is_sep(prev_byte)) &&
             (win_fill == flen || is_sep(win_bytes[flen]))) begin
            hit = 1'b1;
            for (j = 0; j < flen; j++)
               if (fold(win_bytes[j]) != fold(word_at(cfg_find_lo, cfg_find_hi, j)))
                  hit = 1'b0;
         end
         at_start = 1'b0;
         if (hit) begin
            for (j = 0; j < rlen; j++)
               outs.push_back(text_out(word_at(cfg_repl_lo, cfg_repl_hi, j), 1'b1));
            prev_byte = win_bytes[flen - 1];
            any_hit   = 1'b1;
            hits_predicted++;
            drop_front(flen);
         end else begin
            outs.push_back(text_out(win_bytes[0], 1'b1));
            prev_byte = win_bytes[0];
            drop_front(1);
         end
      end
      if (r.in_last) begin
         if (outs.size() == 0)
            outs.push_back(text_out(8'h00, 1'b0));
         o = outs.pop_back();
         o.out_last   = 1'b1;
         o.word_found = any_hit;
         outs.push_back(o);
         clear_stream();
      end
      foreach (outs[i])
         pending_text_out.push_back(outs[i]);
   endtask

   task automatic send_byte(logic [7:0] b, logic last);
      wwfr_pkg::req_type r;
      int      gap;
      r.in_byte = b;
      r.in_last = last;
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      scan_byte(r);
      req_sent++;
   endtask

   task automatic send_string(string s, logic last);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], last && (i == s.len() - 1));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_text_out.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [wwfr_pkg::CSR_IDX_W-1:0] idx,
                            logic [wwfr_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      unique case (idx)
         wwfr_pkg::CSR_FIND_LO:  cfg_find_lo = val;
         wwfr_pkg::CSR_FIND_HI:  cfg_find_hi = val;
         wwfr_pkg::CSR_FIND_LEN: begin
            cfg_find_len = val[4:0];
            clear_stream();
         end
         wwfr_pkg::CSR_REPL_LO:  cfg_repl_lo = val;
         wwfr_pkg::CSR_REPL_HI:  cfg_repl_hi = val;
         wwfr_pkg::CSR_REPL_LEN: cfg_repl_len = val[4:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [63:0] find_lo, logic [63:0] find_hi, logic [63:0] find_len,
                            logic [63:0] repl_lo, logic [63:0] repl_hi, logic [63:0] repl_len);
      wait_idle();
      write_reg(wwfr_pkg::CSR_FIND_LO, find_lo);
      write_reg(wwfr_pkg::CSR_FIND_HI, find_hi);
      write_reg(wwfr_pkg::CSR_FIND_LEN, find_len);
      write_reg(wwfr_pkg::CSR_REPL_LO, repl_lo);
      write_reg(wwfr_pkg::CSR_REPL_HI, repl_hi);
      write_reg(wwfr_pkg::CSR_REPL_LEN, repl_len);
   endtask

   task automatic send_text();
      logic [7:0] txt [$];
      int         ntok, kind, elen, k, i, n;
      elen = (cfg_find_len > MAX_WORD) ? MAX_WORD : cfg_find_len;
      ntok = $urandom_range(1, 5);
      if ($urandom_range(0, 4) == 0)
         txt.push_back(rand_sep());
      for (i = 0; i < ntok; i++) begin
         if (i > 0) begin
            k = $urandom_range(0, 9);
            if (k != 0)
               txt.push_back(rand_sep());
            if (k > 7)
               txt.push_back(rand_sep());
         end
         kind = $urandom_range(0, 19);
         if (elen == 0 && kind < 13)
            kind = 13;
         if (kind == 11)
            txt.push_back(rand_letter());
         if (kind < 12) begin
            for (k = 0; k < elen; k++)
               txt.push_back(mix_case(word_at(cfg_find_lo, cfg_find_hi, k)));
            if (kind == 10)
               txt.push_back(rand_letter());
         end else if (kind == 12) begin
            // truncated word, often right at the end of the text
            for (k = 0; k < elen - 1; k++)
               txt.push_back(mix_case(word_at(cfg_find_lo, cfg_find_hi, k)));
            if (elen == 1)
               txt.push_back(rand_letter());
         end else if (kind < 17) begin
            n = $urandom_range(1, 5);
            for (k = 0; k < n; k++)
               txt.push_back(rand_letter());
         end else begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
               txt.push_back(8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 3) == 0)
         txt.push_back(rand_sep());
      for (i = 0; i < txt.size(); i++)
         send_byte(txt[i], i == txt.size() - 1);
   endtask

   task automatic test_reset_word();
      // after reset the word is a single zero byte and matches are deleted
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   task automatic test_match_rules();
      configure(64'hFFFF_FFFF_FFFF_6241, '1, 64'd2, 64'h0000_0000_005A_5958, 64'd0, 64'd3);
      send_string("AB.xab ab", 1'b1);
      send_string("ab0~ab", 1'b1);
      send_string("a", 1'b1);
   endtask

   task automatic test_zero_length();
      configure(64'h6261, 64'd0, 64'd0, 64'h51, 64'd0, 64'd1);
      write_reg(CSR_SPARE_A, {$urandom, $urandom});
      write_reg(CSR_SPARE_B, {$urandom, $urandom});
      send_string("ab", 1'b1);
   endtask

   task automatic test_restart_mid_text();
      configure(64'h636261, 64'd0, 64'd3, 64'd0, 64'd0, 64'd0);
      send_string("ab", 1'b0);
      wait_idle();
      write_reg(wwfr_pkg::CSR_FIND_LEN, 64'd2);
      send_string("ab", 1'b0);
      wait_idle();
      write_reg(wwfr_pkg::CSR_REPL_LO, 64'h51);
      write_reg(wwfr_pkg::CSR_REPL_LEN, 64'd1);
      send_string(" ", 1'b1);
   endtask

   task automatic test_output_backpressure();
      configure(64'h6261, 64'd0, 64'd2, {$urandom, $urandom}, {$urandom, $urandom}, 64'd16);
      gaps_on = 1'b0;
      hold_asked++;
      send_string("ab ab ab ab", 1'b1);
      wait_idle();
      gaps_on = 1'b1;
      send_string("ab,AB", 1'b1);
   endtask

   task automatic test_random_texts();
      logic [63:0] flen_w, rlen_w;
      int          p, start;
      p = 0;
      while (random_sent < RANDOM_ITEMS) begin
         flen_w = 64'd0;
         rlen_w = 64'd0;
         unique case (p % 6)
            0: begin
               flen_w[4:0] = 5'($urandom_range(1, 4));
               rlen_w[4:0] = 5'($urandom_range(0, 4));
            end
            1: begin
               flen_w[4:0] = 5'd1;
               rlen_w[4:0] = 5'd0;
            end
            2: begin
               flen_w[4:0] = 5'd16;
               rlen_w[4:0] = 5'd16;
            end
            3: begin
               flen_w = {$urandom, $urandom};
               rlen_w = {$urandom, $urandom};
               flen_w[4:0] = 5'($urandom_range(17, 31));
               rlen_w[4:0] = 5'($urandom_range(17, 31));
            end
            4: begin
               flen_w[4:0] = 5'd0;
               rlen_w[4:0] = 5'($urandom_range(0, 16));
            end
            default: begin
               flen_w[4:0] = 5'($urandom_range(1, 16));
               rlen_w[4:0] = 5'($urandom_range(0, 16));
            end
         endcase
         configure(rand_word_half(), rand_word_half(), flen_w,
                   {$urandom, $urandom}, {$urandom, $urandom}, rlen_w);
         gaps_on   = (p % 4 == 0) || (p % 4 == 2);
         stalls_on = (p % 4 == 0) || (p % 4 == 1);
         start = req_sent;
         while (req_sent - start < 50) begin
            if ($urandom_range(0, 7) == 0)
               wait_idle();
            send_text();
         end
         random_sent += req_sent - start;
         p++;
      end
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   // receiver: per-response random stall plus an occasional long hold-off
   always @(negedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left   = HOLD_CYCLES;
      end
      if (rsp_drawn != rsp_checked) begin
         rsp_drawn = rsp_checked;
         wait_left = stalls_on ? $urandom_range(0, 8) : 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (wait_left > 0) begin
         wait_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got = rsp_data;
         if (pending_text_out.size() == 0) begin
            $error("response with no request pending: %p", got);
            fail_count++;
         end else begin
            want = pending_text_out.pop_front();
            if (got.out_byte !== want.out_byte) begin
               $error("out_byte expected %02h actual %02h", want.out_byte, got.out_byte);
               fail_count++;
            end
            if (got.byte_present !== want.byte_present) begin
               $error("byte_present expected %0b actual %0b", want.byte_present,
                      got.byte_present);
               fail_count++;
            end
            if (got.out_last !== want.out_last) begin
               $error("out_last expected %0b actual %0b", want.out_last, got.out_last);
               fail_count++;
            end
            if (got.word_found !== want.word_found) begin
               $error("word_found expected %0b actual %0b", want.word_found, got.word_found);
               fail_count++;
            end
         end
         rsp_checked++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  pending_text_out.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int waited, bad;
      cfg_find_lo  = '0;
      cfg_find_hi  = '0;
      cfg_repl_lo  = '0;
      cfg_repl_hi  = '0;
      cfg_find_len = 5'd1;
      cfg_repl_len = 5'd0;
      clear_stream();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_word();
      test_match_rules();
      test_zero_length();
      test_restart_mid_text();
      test_output_backpressure();
      test_random_texts();

      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (pending_text_out.size() != 0 && waited < END_WAIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      bad = fail_count;
      if (pending_text_out.size() != 0) begin
         $error("%0d expected responses never arrived", pending_text_out.size());
         bad++;
      end
      $display("sent %0d text bytes over reset, directed and random word settings", req_sent);
      $display("checked %0d output bytes, %0d whole-word matches predicted", rsp_checked,
               hits_predicted);
      if (bad == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
